FILE: rtl/core/stt_pkg.sv
package stt_pkg;

  // Default counter width for cursor, line counter and token registers
  localparam int POSITION_BITS_DEF = 16;

  // Result buffer: up to two words enter per accepted item
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

  // Characters with a role of their own
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SYMBOL  = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_STRING  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_INVALID = 4'd1,
    KIND_SYMBOL  = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_EQUALS  = 4'd4,
    KIND_COMMENT = 4'd5,
    KIND_NUMBER  = 4'd6,
    KIND_CLOSE   = 4'd7,
    KIND_OPEN    = 4'd8,
    KIND_COLON   = 4'd9
  } kind_t;

  // One token word as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] start_line;
    logic        last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic kind_t pending_kind(input mode_t m);
    kind_t k;
    unique case (m)
      MODE_SYMBOL:  k = KIND_SYMBOL;
      MODE_NUMBER:  k = KIND_NUMBER;
      MODE_COMMENT: k = KIND_COMMENT;
      default:      k = KIND_STRING;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/stt_scan.sv
// One tokenizer step: next state and up to two token words for one item
module stt_scan #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
  input  logic                     op,
  input  logic [7:0]               ch,
  input  stt_pkg::mode_t           mode,
  input  logic [POSITION_BITS-1:0] token_start,
  input  logic [POSITION_BITS-1:0] token_length,
  input  logic [POSITION_BITS-1:0] token_line,
  input  logic [POSITION_BITS-1:0] position,
  input  logic [POSITION_BITS-1:0] line_count,
  output stt_pkg::mode_t           mode_next,
  output logic [POSITION_BITS-1:0] token_start_next,
  output logic [POSITION_BITS-1:0] token_length_next,
  output logic [POSITION_BITS-1:0] token_line_next,
  output logic [POSITION_BITS-1:0] position_next,
  output logic [POSITION_BITS-1:0] line_count_next,
  output logic [1:0]               res_cnt,
  output stt_pkg::res_t            res0,
  output stt_pkg::res_t            res1
);

  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] line_inc;
  logic [POSITION_BITS-1:0] len_inc;
  logic                     absorb;
  logic                     close_str;
  logic                     a_valid;
  logic                     b_valid;
  stt_pkg::res_t            a_res;
  stt_pkg::res_t            b_res;
  stt_pkg::res_t            pend;

  // Saturating counters
  assign pos_inc  = (position == '1) ? position : position + 1'b1;
  assign line_inc = (line_count == '1) ? line_count : line_count + 1'b1;
  assign len_inc  = (token_length == '1) ? token_length : token_length + 1'b1;

  assign pend = '{kind:         stt_pkg::pending_kind(mode),
                  start_offset: 16'(token_start),
                  text_length:  16'(token_length),
                  start_line:   16'(token_line),
                  last:         1'b0};

  // Decide whether the pending token takes this character
  always_comb begin
    absorb    = 1'b0;
    close_str = 1'b0;
    unique case (mode)
      stt_pkg::MODE_SYMBOL:
        absorb = stt_pkg::is_alpha(ch) || stt_pkg::is_digit(ch) ||
                 (ch == stt_pkg::CH_USCORE) || (ch == stt_pkg::CH_TAB) ||
                 (ch == stt_pkg::CH_VT) || (ch == stt_pkg::CH_FF) ||
                 (ch == stt_pkg::CH_CR);
      stt_pkg::MODE_NUMBER:
        absorb = stt_pkg::is_digit(ch) || (ch == stt_pkg::CH_DOT);
      stt_pkg::MODE_COMMENT:
        absorb = (ch != stt_pkg::CH_LF);
      stt_pkg::MODE_STRING: begin
        close_str = (ch == stt_pkg::CH_QUOTE);
        absorb    = (ch != stt_pkg::CH_QUOTE);
      end
      default: absorb = 1'b0;
    endcase
  end

  // Next state and the two candidate words
  always_comb begin
    mode_next         = mode;
    token_start_next  = token_start;
    token_length_next = token_length;
    token_line_next   = token_line;
    position_next     = pos_inc;
    line_count_next   = (ch == stt_pkg::CH_LF) ? line_inc : line_count;
    a_valid           = 1'b0;
    b_valid           = 1'b0;
    a_res             = pend;
    b_res             = '{kind:         stt_pkg::KIND_INVALID,
                          start_offset: 16'(position),
                          text_length:  16'd0,
                          start_line:   16'(line_count),
                          last:         1'b0};

    if (op == stt_pkg::OP_END) begin
      // Flush the pending token, then the end word; clear everything
      a_valid            = (mode != stt_pkg::MODE_IDLE);
      b_valid            = 1'b1;
      b_res.kind         = stt_pkg::KIND_END;
      mode_next          = stt_pkg::MODE_IDLE;
      token_start_next   = '0;
      token_length_next  = '0;
      token_line_next    = '0;
      position_next      = '0;
      line_count_next    = '0;
    end else if (close_str) begin
      a_valid   = 1'b1;
      mode_next = stt_pkg::MODE_IDLE;
    end else if (absorb) begin
      token_length_next = len_inc;
    end else begin
      // Close the pending token and start afresh on this character
      a_valid   = (mode != stt_pkg::MODE_IDLE);
      mode_next = stt_pkg::MODE_IDLE;
      priority if (stt_pkg::is_space(ch)) begin
        b_valid = 1'b0;
      end else if (ch == stt_pkg::CH_EQUALS) begin
        b_valid           = 1'b1;
        b_res.kind        = stt_pkg::KIND_EQUALS;
        b_res.text_length = 16'd1;
      end else if (ch == stt_pkg::CH_LBRACK) begin
        b_valid           = 1'b1;
        b_res.kind        = stt_pkg::KIND_OPEN;
        b_res.text_length = 16'd1;
      end else if (ch == stt_pkg::CH_RBRACK) begin
        b_valid           = 1'b1;
        b_res.kind        = stt_pkg::KIND_CLOSE;
        b_res.text_length = 16'd1;
      end else if (ch == stt_pkg::CH_COLON) begin
        b_valid           = 1'b1;
        b_res.kind        = stt_pkg::KIND_COLON;
        b_res.text_length = 16'd1;
      end else if (ch == stt_pkg::CH_PERCENT) begin
        mode_next         = stt_pkg::MODE_COMMENT;
        token_start_next  = position;
        token_length_next = POSITION_BITS'(1);
        token_line_next   = line_count;
      end else if (stt_pkg::is_digit(ch) || (ch == stt_pkg::CH_MINUS)) begin
        mode_next         = stt_pkg::MODE_NUMBER;
        token_start_next  = position;
        token_length_next = POSITION_BITS'(1);
        token_line_next   = line_count;
      end else if (stt_pkg::is_alpha(ch) || (ch == stt_pkg::CH_USCORE)) begin
        mode_next         = stt_pkg::MODE_SYMBOL;
        token_start_next  = position;
        token_length_next = POSITION_BITS'(1);
        token_line_next   = line_count;
      end else if (ch == stt_pkg::CH_QUOTE) begin
        // String text starts after the quote
        mode_next         = stt_pkg::MODE_STRING;
        token_start_next  = pos_inc;
        token_length_next = '0;
        token_line_next   = line_count;
      end else begin
        b_valid = 1'b1;
      end
    end
  end

  // Pack the words in order and mark the final one
  always_comb begin
    res0    = a_valid ? a_res : b_res;
    res1    = b_res;
    res_cnt = 2'(a_valid) + 2'(b_valid);
    if (a_valid && b_valid) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

endmodule

FILE: rtl/core/stt_obuf.sv
// Small result queue: takes up to two words a cycle, gives one while out_ready is high
module stt_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  stt_pkg::res_t push0,
  input  stt_pkg::res_t push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::res_t out_word
);

  stt_pkg::res_t                 mem [stt_pkg::OBUF_DEPTH];
  logic [stt_pkg::OBUF_AW-1:0]   wr_ptr;
  logic [stt_pkg::OBUF_AW-1:0]   rd_ptr;
  logic [stt_pkg::OBUF_AW:0]     count;
  logic [stt_pkg::OBUF_AW:0]     count_next;
  logic                          pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_word   = mem[rd_ptr];
  assign room       = (count <= (stt_pkg::OBUF_AW + 1)'(stt_pkg::OBUF_DEPTH - 2));
  assign count_next = count + (stt_pkg::OBUF_AW + 1)'(push_cnt)
                      - (stt_pkg::OBUF_AW + 1)'(pop);

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stt_pkg::OBUF_AW'(push_cnt);
      rd_ptr <= rd_ptr + stt_pkg::OBUF_AW'(pop);
      count  <= count_next;
    end
  end

endmodule

FILE: rtl/core/script_text_tokenizer_unit.sv
// Channel  Dir  tvalid/tready        Payload
// s        in   s_tvalid, s_tready   s_tuser = op, s_tdata = ch
// m        out  m_tvalid, m_tready   m_tuser = kind, m_tdata = offset/length/line,
//                                    m_tlast = last word of an item
//
// One input word per cycle; its token words are in the result queue the next
// cycle. An item yields up to two words and the output drains one per cycle
// while m_tready is high, so a run of two-word items is held back by the
// output port. s_tready drops only when the four-entry queue has fewer than
// two free slots. Synchronous reset empties the queue and clears all state.
module script_text_tokenizer_unit #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] start_offset, [31:16] text_length,
                                 // [47:32] start_line
  output logic [3:0]  m_tuser,   // [3:0] kind
  output logic        m_tlast    // last
);

  stt_pkg::mode_t           mode;
  stt_pkg::mode_t           mode_next;
  logic [POSITION_BITS-1:0] token_start;
  logic [POSITION_BITS-1:0] token_start_next;
  logic [POSITION_BITS-1:0] token_length;
  logic [POSITION_BITS-1:0] token_length_next;
  logic [POSITION_BITS-1:0] token_line;
  logic [POSITION_BITS-1:0] token_line_next;
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] line_count;
  logic [POSITION_BITS-1:0] line_count_next;
  logic [1:0]               res_cnt;
  stt_pkg::res_t            res0;
  stt_pkg::res_t            res1;
  stt_pkg::res_t            head;
  logic                     room;
  logic                     accept;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  stt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .op                (s_tuser),
    .ch                (s_tdata),
    .mode              (mode),
    .token_start       (token_start),
    .token_length      (token_length),
    .token_line        (token_line),
    .position          (position),
    .line_count        (line_count),
    .mode_next         (mode_next),
    .token_start_next  (token_start_next),
    .token_length_next (token_length_next),
    .token_line_next   (token_line_next),
    .position_next     (position_next),
    .line_count_next   (line_count_next),
    .res_cnt           (res_cnt),
    .res0              (res0),
    .res1              (res1)
  );

  // Hold tokenizer state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= stt_pkg::MODE_IDLE;
      token_start  <= '0;
      token_length <= '0;
      token_line   <= '0;
      position     <= '0;
      line_count   <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      token_line   <= token_line_next;
      position     <= position_next;
      line_count   <= line_count_next;
    end
  end

  stt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (accept ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (head)
  );

  assign m_tuser = head.kind;
  assign m_tdata = {head.start_line, head.text_length, head.start_offset};
  assign m_tlast = head.last;

endmodule

FILE: rtl/core/stt_checker.sv
// Port-level checks on the tokenizer output
module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // The end token closes its item
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == stt_pkg::KIND_END) |-> m_tlast)
    else $error("end token not marked last");

  // End and invalid tokens carry no text
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == stt_pkg::KIND_END) || (m_tuser == stt_pkg::KIND_INVALID))
    |-> (m_tdata[31:16] == 16'd0))
    else $error("end or invalid token with nonzero length");

endmodule

bind script_text_tokenizer_unit stt_checker u_stt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: verif/stt_token_checker.sv
module stt_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [15:0] start_offset, [31:16] text_length,
                                 // [47:32] start_line
  input  logic [3:0]  m_tuser,   // [3:0] kind
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding
);

  // Tokenizer state as the predictor sees it
  stt_pkg::mode_t cur_mode;
  logic [15:0]    tok_start;
  logic [15:0]    tok_len;
  logic [15:0]    tok_line;
  logic [15:0]    cursor;
  logic [15:0]    line_no;

  stt_pkg::res_t item_tokens[$];
  stt_pkg::res_t token_words_due[$];
  stt_pkg::res_t want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Whitespace other than space and newline keeps a symbol going
  function automatic logic soft_blank(input logic [7:0] c);
    return (c == stt_pkg::CH_TAB) || (c == stt_pkg::CH_VT) ||
           (c == stt_pkg::CH_FF) || (c == stt_pkg::CH_CR);
  endfunction

  task automatic add_token(input stt_pkg::kind_t k, input logic [15:0] offs,
                           input logic [15:0] len, input logic [15:0] line);
    stt_pkg::res_t r;
    r.kind         = k;
    r.start_offset = offs;
    r.text_length  = len;
    r.start_line   = line;
    r.last         = 1'b0;
    item_tokens.push_back(r);
  endtask

  task automatic move_cursor(input logic [7:0] c);
    cursor = bump(cursor);
    if (c == stt_pkg::CH_LF) line_no = bump(line_no);
  endtask

  task automatic open_token(input stt_pkg::mode_t m, input logic [15:0] offs,
                            input logic [15:0] len);
    cur_mode  = m;
    tok_start = offs;
    tok_len   = len;
    tok_line  = line_no;
  endtask

  // Emit whatever token is pending and go idle
  task automatic close_token();
    stt_pkg::kind_t k;
    case (cur_mode)
      stt_pkg::MODE_SYMBOL:  k = stt_pkg::KIND_SYMBOL;
      stt_pkg::MODE_NUMBER:  k = stt_pkg::KIND_NUMBER;
      stt_pkg::MODE_COMMENT: k = stt_pkg::KIND_COMMENT;
      default:               k = stt_pkg::KIND_STRING;
    endcase
    if (cur_mode != stt_pkg::MODE_IDLE) add_token(k, tok_start, tok_len, tok_line);
    cur_mode = stt_pkg::MODE_IDLE;
  endtask

  task automatic clear_text();
    cur_mode  = stt_pkg::MODE_IDLE;
    tok_start = '0;
    tok_len   = '0;
    tok_line  = '0;
    cursor    = '0;
    line_no   = '0;
  endtask

  // Handle a character with nothing pending
  task automatic start_token(input logic [7:0] c);
    case (c)
      stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_LF,
      stt_pkg::CH_VT, stt_pkg::CH_FF, stt_pkg::CH_CR: ;
      stt_pkg::CH_EQUALS:  add_token(stt_pkg::KIND_EQUALS, cursor, 16'd1, line_no);
      stt_pkg::CH_LBRACK:  add_token(stt_pkg::KIND_OPEN, cursor, 16'd1, line_no);
      stt_pkg::CH_RBRACK:  add_token(stt_pkg::KIND_CLOSE, cursor, 16'd1, line_no);
      stt_pkg::CH_COLON:   add_token(stt_pkg::KIND_COLON, cursor, 16'd1, line_no);
      stt_pkg::CH_PERCENT: open_token(stt_pkg::MODE_COMMENT, cursor, 16'd1);
      stt_pkg::CH_QUOTE:   open_token(stt_pkg::MODE_STRING, bump(cursor), 16'd0);
      default: begin
        if (digit_byte(c) || c == stt_pkg::CH_MINUS)
          open_token(stt_pkg::MODE_NUMBER, cursor, 16'd1);
        else if (letter_byte(c) || c == stt_pkg::CH_USCORE)
          open_token(stt_pkg::MODE_SYMBOL, cursor, 16'd1);
        else add_token(stt_pkg::KIND_INVALID, cursor, 16'd0, line_no);
      end
    endcase
    move_cursor(c);
  endtask

  // Work out the token words one accepted input word causes
  task automatic tokenize_word(input logic op, input logic [7:0] c);
    logic keep;
    logic quoted;
    keep   = 1'b0;
    quoted = 1'b0;
    item_tokens.delete();
    if (op == stt_pkg::OP_END) begin
      close_token();
      add_token(stt_pkg::KIND_END, cursor, 16'd0, line_no);
      clear_text();
    end else begin
      case (cur_mode)
        stt_pkg::MODE_SYMBOL:
          keep = letter_byte(c) || digit_byte(c) || c == stt_pkg::CH_USCORE ||
                 soft_blank(c);
        stt_pkg::MODE_NUMBER:  keep = digit_byte(c) || c == stt_pkg::CH_DOT;
        stt_pkg::MODE_COMMENT: keep = (c != stt_pkg::CH_LF);
        stt_pkg::MODE_STRING: begin
          if (c == stt_pkg::CH_QUOTE) quoted = 1'b1;
          else keep = 1'b1;
        end
        default:               keep = 1'b0;
      endcase
      if (quoted) begin
        close_token();
        move_cursor(c);
      end else if (keep) begin
        tok_len = bump(tok_len);
        move_cursor(c);
      end else begin
        close_token();
        start_token(c);
      end
    end
    if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last = 1'b1;
    foreach (item_tokens[i]) token_words_due.push_back(item_tokens[i]);
  endtask

  task automatic check_field(input string label, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (exp_val != got_val) begin
      mismatches++;
      $display("%0t: token %s mismatch, expected %0d, actual %0d",
               $time, label, exp_val, got_val);
    end
  endtask

  // Predict on every accepted input word, compare every accepted token word
  always @(posedge clk) begin
    if (rst) begin
      clear_text();
      token_words_due.delete();
    end else begin
      if (s_tvalid && s_tready) tokenize_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (token_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected token word, expected none, actual kind %0d offset %0d",
                   $time, m_tuser, m_tdata[15:0]);
        end else begin
          want = token_words_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(m_tuser));
          check_field("start_offset", want.start_offset, m_tdata[15:0]);
          check_field("text_length", want.text_length, m_tdata[31:16]);
          check_field("start_line", want.start_line, m_tdata[47:32]);
          check_field("last", 16'(want.last), 16'(m_tlast));
        end
      end
    end
    outstanding <= token_words_due.size();
  end

endmodule

FILE: verif/tb_script_text_tokenizer_unit.sv
module tb_script_text_tokenizer_unit;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 1450;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  int mismatches;
  int outstanding;
  int sent_words;
  int cycle_count;
  bit tx_calm;
  bit rx_calm;
  bit hold_req;

  script_text_tokenizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  stt_token_checker token_audit (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bail out if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("Regression FAIL");
    $finish;
  end

  // Drain token words with random stalls and one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk);
      if (m_tvalid && m_tready) stall_left = rx_calm ? 0 : $urandom_range(0, 15);
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic op, input logic [7:0] c);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_words++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_word(stt_pkg::OP_CHAR, c);
  endtask

  task automatic send_end();
    send_word(stt_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_of(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x);
    return c;
  endfunction

  // Emit one random token shape, mostly well formed, sometimes broken
  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 18);
    n    = $urandom_range(0, 6);
    case (pick)
      0, 1, 2: repeat (n + 1) send_char(pick_of(" \011\012\013\014\015"));
      3, 4, 5, 18: begin
        send_char(pick_of("_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        repeat (n) send_char(pick_of("az_09QZ\011\013\014\015kM5"));
        if (pick == 18) send_char(pick_of("=[]:"));
      end
      6, 7: begin
        send_char(pick_of("-0123456789"));
        repeat (n) send_char(pick_of(".0123456789"));
      end
      8, 9: begin
        send_char(stt_pkg::CH_PERCENT);
        repeat (n) send_char(byte_except(stt_pkg::CH_LF));
        if ($urandom_range(0, 7) != 0) send_char(stt_pkg::CH_LF);
      end
      10, 11: begin
        send_char(stt_pkg::CH_QUOTE);
        repeat (n) send_char(byte_except(stt_pkg::CH_QUOTE));
        if ($urandom_range(0, 5) != 0) send_char(stt_pkg::CH_QUOTE);
      end
      12, 13, 14: send_char(pick_of("=[]:"));
      15, 16: send_char(8'($urandom_range(0, 255)));
      default: send_end();
    endcase
  endtask

  initial begin
    string opening;
    int base;
    int shapes;
    bit pressed;
    opening  = "x\t_\0131 -3.5[%c\n\"q\n\"]:";
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = stt_pkg::OP_CHAR;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    hold_req = 1'b0;
    pressed  = 1'b0;
    shapes   = 0;
    sent_words = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every token kind but equals, odd bytes, end of text, open string at end
    for (int i = 0; i < opening.len(); i++) send_char(opening[i]);
    send_char(8'h80);
    send_char(8'h00);
    send_char(8'hFF);
    send_end();
    send_char(stt_pkg::CH_QUOTE);
    send_char("a");
    send_char("b");
    send_end();

    // Random token streams, with one long receiver hold-off halfway
    base = sent_words;
    while (sent_words - base < RANDOM_ITEMS) begin
      if (!pressed && sent_words - base > RANDOM_ITEMS / 2) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        repeat (24) begin
          send_char("b");
          send_char(stt_pkg::CH_EQUALS);
        end
      end
      shapes++;
      if (shapes % 16 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      send_random_token();
    end
    send_end();
    s_tvalid <= 1'b0;

    // Drain and settle
    wait (outstanding == 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/stt_pkg.sv
rtl/core/stt_scan.sv
rtl/core/stt_obuf.sv
rtl/core/script_text_tokenizer_unit.sv
rtl/core/stt_checker.sv
verif/stt_token_checker.sv
verif/tb_script_text_tokenizer_unit.sv
